FILE: src/iplp_pkg.sv
// Shared types, widths, register codes and reset values of the iso packet length planner.
// No dependencies; the CSR bank, controller, datapath and top level take names from here by scope.
package iplp_pkg;

   // Defaults of the top level parameters
   localparam int unsigned MAX_PACKETS_DEF = 64;
   localparam int unsigned FRAC_BITS_DEF   = 16;

   // Field and register widths
   localparam int unsigned CHANNEL_W   = 4;
   localparam int unsigned SAMPLE_W    = 3;
   localparam int unsigned MAX_SPP_W   = 11;
   localparam int unsigned PPT_W       = 7;
   localparam int unsigned DEF_RATE_W  = 27;
   localparam int unsigned CSR_DATA_W  = 27;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned RATE_W      = 32;
   localparam int unsigned OFFSET_W    = 22;
   localparam int unsigned LENGTH_W    = 17;
   localparam int unsigned FRAME_W     = 7;
   localparam int unsigned WHOLE_W     = 11;
   localparam int unsigned STEP_W      = 18;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_COUNT  = 3'd0,
      CSR_SAMPLE_BYTES   = 3'd1,
      CSR_MAX_SPP        = 3'd2,
      CSR_PACKETS        = 3'd3,
      CSR_DEFAULT_RATE   = 3'd4
   } csr_index_type;

   // Reset values
   localparam logic [CHANNEL_W-1:0]  CHANNEL_COUNT_RST = 4'd2;
   localparam logic [SAMPLE_W-1:0]   SAMPLE_BYTES_RST  = 3'd2;
   localparam logic [MAX_SPP_W-1:0]  MAX_SPP_RST       = 11'd48;
   localparam logic [PPT_W-1:0]      PACKETS_RST       = 7'd8;
   localparam logic [DEF_RATE_W-1:0] DEFAULT_RATE_RST  = 27'd3145728;

   typedef struct packed {
      logic [CHANNEL_W-1:0]  channel_count;
      logic [SAMPLE_W-1:0]   sample_bytes;
      logic [MAX_SPP_W-1:0]  max_samples_per_packet;
      logic [PPT_W-1:0]      packets_per_transfer;
      logic [DEF_RATE_W-1:0] default_rate;
   } cfg_type;

   typedef struct packed {
      logic signed [RATE_W-1:0] feedback_rate;
   } req_payload_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] packet_offset;
      logic [LENGTH_W-1:0] packet_length;
      logic                zero_fill;
      logic                last_packet;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic clamp_en;
      logic setup_en;
      logic plan_en;
      logic acc_clear;
      logic emit_packet;
      logic emit_fill;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic non_positive;
      logic is_max;
      logic count_zero;
      logic last_packet;
      logic out_free;
   } status_type;

endpackage

FILE: src/iplp_stream_if.sv
// Valid/ready channel carrying one payload word per handshake.
// Payload type is supplied by the instantiating level (see iplp_pkg).
interface iplp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/iplp_csr.sv
// Configuration register bank of the iso packet length planner.
// Depends on iplp_pkg for register codes, widths and reset values.
module iplp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [iplp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [iplp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output iplp_pkg::cfg_type                cfg
);

   iplp_pkg::cfg_type cfg_ff;
   iplp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (iplp_pkg::csr_index_type'(csr_index))
            iplp_pkg::CSR_CHANNEL_COUNT: begin
               cfg_in.channel_count = csr_wdata[iplp_pkg::CHANNEL_W-1:0];
            end
            iplp_pkg::CSR_SAMPLE_BYTES: begin
               cfg_in.sample_bytes = csr_wdata[iplp_pkg::SAMPLE_W-1:0];
            end
            iplp_pkg::CSR_MAX_SPP: begin
               cfg_in.max_samples_per_packet = csr_wdata[iplp_pkg::MAX_SPP_W-1:0];
            end
            iplp_pkg::CSR_PACKETS: begin
               cfg_in.packets_per_transfer = csr_wdata[iplp_pkg::PPT_W-1:0];
            end
            iplp_pkg::CSR_DEFAULT_RATE: begin
               cfg_in.default_rate = csr_wdata[iplp_pkg::DEF_RATE_W-1:0];
            end
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count          <= iplp_pkg::CHANNEL_COUNT_RST;
         cfg_ff.sample_bytes           <= iplp_pkg::SAMPLE_BYTES_RST;
         cfg_ff.max_samples_per_packet <= iplp_pkg::MAX_SPP_RST;
         cfg_ff.packets_per_transfer   <= iplp_pkg::PACKETS_RST;
         cfg_ff.default_rate           <= iplp_pkg::DEFAULT_RATE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/iplp_ctrl.sv
// Sequencing state machine of the iso packet length planner.
// Depends on iplp_pkg for the command and status structs.
module iplp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  iplp_pkg::status_type status,
   output iplp_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CLAMP = 6'b000010,
      ST_SETUP = 6'b000100,
      ST_PLAN  = 6'b001000,
      ST_RUN   = 6'b010000,
      ST_FILL  = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            cmd.clamp_en = 1'b1;
            state_in     = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup_en = 1'b1;
            state_in     = status.non_positive ? ST_FILL : ST_PLAN;
         end
         ST_PLAN: begin
            cmd.plan_en   = 1'b1;
            cmd.acc_clear = status.is_max;
            state_in      = status.count_zero ? ST_IDLE : ST_RUN;
         end
         ST_RUN: begin
            if (status.out_free) begin
               cmd.emit_packet = 1'b1;
               if (status.last_packet) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FILL: begin
            if (status.out_free) begin
               cmd.emit_fill = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/iplp_datapath.sv
// Rate clamp, rounding, fraction accumulator and packet offset datapath.
// Depends on iplp_pkg; driven by iplp_ctrl through cmd_type, reports status_type.
module iplp_datapath #(
   parameter int unsigned MAX_PACKETS = iplp_pkg::MAX_PACKETS_DEF,
   parameter int unsigned FRAC_BITS   = iplp_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  iplp_pkg::cfg_type                    cfg,
   input  iplp_pkg::cmd_type                    cmd,
   output iplp_pkg::status_type                 status,
   input  logic signed [iplp_pkg::RATE_W-1:0]   req_feedback_rate,
   output iplp_pkg::rsp_payload_type            rsp_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready
);

   localparam int unsigned RW   = (FRAC_BITS + 12 > 33) ? FRAC_BITS + 12 : 33;
   localparam int unsigned PW   = (FRAC_BITS + iplp_pkg::LENGTH_W > 34) ?
                                  FRAC_BITS + iplp_pkg::LENGTH_W : 34;
   localparam int unsigned AW   = FRAC_BITS + 2;
   localparam int unsigned LW   = iplp_pkg::STEP_W + 1;
   localparam int unsigned CNTW = $clog2(MAX_PACKETS + 1);
   localparam int unsigned OW   = iplp_pkg::OFFSET_W;

   localparam logic signed [AW-1:0] HALF     = AW'(1) << (FRAC_BITS - 1);
   localparam logic signed [AW-1:0] NEG_HALF = -HALF;
   localparam logic signed [AW-1:0] ONE      = AW'(1) << FRAC_BITS;
   localparam logic [RW-1:0]        RND_HALF = RW'(1) << (FRAC_BITS - 1);

   // Request and per-transfer plan
   logic signed [iplp_pkg::RATE_W-1:0] rate_ff, rate_in;
   logic signed [RW-1:0]               clamp_ff, clamp_in;
   logic [PW-1:0]                      total_ff, total_in;
   logic [iplp_pkg::FRAME_W-1:0]       frame_ff, frame_in;
   logic [iplp_pkg::STEP_W-1:0]        step_ff, step_in;
   logic signed [FRAC_BITS-1:0]        frac_ff, frac_in;
   logic                               is_max_ff, is_max_in;
   logic [CNTW-1:0]                    count_ff, count_in;
   logic signed [LW-1:0]               len_up_ff, len_up_in;
   logic signed [LW-1:0]               len_eq_ff, len_eq_in;
   logic signed [LW-1:0]               len_dn_ff, len_dn_in;

   // Running state
   logic [CNTW-1:0]        pkt_ff, pkt_in;
   logic signed [AW-1:0]   acc_ff, acc_in;
   logic [OW-1:0]          offset_ff, offset_in;

   // Output register
   iplp_pkg::rsp_payload_type out_ff, out_in;
   logic                      out_valid_ff, out_valid_in;

   // Combinational helpers
   logic signed [RW-1:0]            rate_ext;
   logic signed [RW-1:0]            def_ext;
   logic signed [RW-1:0]            max_fx;
   logic signed [RW-1:0]            rate_sel;
   logic [RW-1:0]                   round_sum;
   logic [iplp_pkg::WHOLE_W-1:0]    whole;
   logic signed [AW-1:0]            acc_sum;
   logic signed [AW-1:0]            acc_next;
   logic signed [LW-1:0]            len_sel;
   logic                            last_w;
   logic                            out_free;

   assign out_free = !out_valid_ff || rsp_ready;
   assign last_w   = ((pkt_ff + CNTW'(1)) == count_ff);

   always_comb begin
      rate_ext = {{(RW - iplp_pkg::RATE_W){rate_ff[iplp_pkg::RATE_W-1]}}, rate_ff};
      def_ext  = {{(RW - iplp_pkg::DEF_RATE_W){1'b0}}, cfg.default_rate};
      max_fx   = (RW'(cfg.max_samples_per_packet)) << FRAC_BITS;
      rate_sel = (rate_ff == '0) ? def_ext : rate_ext;

      round_sum = clamp_ff + RND_HALF;
      whole     = round_sum[FRAC_BITS +: iplp_pkg::WHOLE_W];

      acc_sum = acc_ff + {{2{frac_ff[FRAC_BITS-1]}}, frac_ff};
      if (acc_sum > HALF) begin
         acc_next = acc_sum - ONE;
         len_sel  = len_up_ff;
      end else if (acc_sum < NEG_HALF) begin
         acc_next = acc_sum + ONE;
         len_sel  = len_dn_ff;
      end else begin
         acc_next = acc_sum;
         len_sel  = len_eq_ff;
      end
   end

   always_comb begin
      rate_in      = rate_ff;
      clamp_in     = clamp_ff;
      total_in     = total_ff;
      frame_in     = frame_ff;
      step_in      = step_ff;
      frac_in      = frac_ff;
      is_max_in    = is_max_ff;
      count_in     = count_ff;
      len_up_in    = len_up_ff;
      len_eq_in    = len_eq_ff;
      len_dn_in    = len_dn_ff;
      pkt_in       = pkt_ff;
      acc_in       = acc_ff;
      offset_in    = offset_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      if (cmd.capture) begin
         rate_in = req_feedback_rate;
      end

      // Select default, clamp to maximum; zero-fill total and frame size alongside
      if (cmd.clamp_en) begin
         clamp_in = (rate_sel > max_fx) ? max_fx : rate_sel;
         total_in = PW'(cfg.default_rate) * PW'(cfg.packets_per_transfer);
         frame_in = iplp_pkg::FRAME_W'(cfg.channel_count) *
                    iplp_pkg::FRAME_W'(cfg.sample_bytes);
      end

      // Round to whole samples, keep signed remainder, saturate packet count
      if (cmd.setup_en) begin
         step_in   = iplp_pkg::STEP_W'(whole) * iplp_pkg::STEP_W'(frame_ff);
         is_max_in = (clamp_ff == max_fx);
         frac_in   = is_max_in ? '0 : clamp_ff[FRAC_BITS-1:0];
         if (32'(cfg.packets_per_transfer) > MAX_PACKETS) begin
            count_in = CNTW'(MAX_PACKETS);
         end else begin
            count_in = CNTW'(cfg.packets_per_transfer);
         end
      end

      // Precompute the three possible packet lengths
      if (cmd.plan_en) begin
         len_eq_in = $signed({1'b0, step_ff});
         len_up_in = $signed({1'b0, step_ff}) +
                     $signed({{(LW - iplp_pkg::FRAME_W){1'b0}}, frame_ff});
         len_dn_in = $signed({1'b0, step_ff}) -
                     $signed({{(LW - iplp_pkg::FRAME_W){1'b0}}, frame_ff});
         pkt_in    = '0;
         offset_in = '0;
      end
      if (cmd.acc_clear) begin
         acc_in = '0;
      end

      if (cmd.emit_packet) begin
         acc_in               = acc_next;
         offset_in            = offset_ff + {{(OW - LW){len_sel[LW-1]}}, len_sel};
         pkt_in               = pkt_ff + CNTW'(1);
         out_in.packet_offset = offset_ff;
         out_in.packet_length = len_sel[iplp_pkg::LENGTH_W-1:0];
         out_in.zero_fill     = 1'b0;
         out_in.last_packet   = last_w;
         out_valid_in         = 1'b1;
      end

      if (cmd.emit_fill) begin
         out_in.packet_offset = '0;
         out_in.packet_length = total_ff[FRAC_BITS +: iplp_pkg::LENGTH_W];
         out_in.zero_fill     = 1'b1;
         out_in.last_packet   = 1'b1;
         out_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pkt_ff       <= '0;
         offset_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         pkt_ff       <= pkt_in;
         offset_ff    <= offset_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff   <= rate_in;
      clamp_ff  <= clamp_in;
      total_ff  <= total_in;
      frame_ff  <= frame_in;
      step_ff   <= step_in;
      frac_ff   <= frac_in;
      is_max_ff <= is_max_in;
      count_ff  <= count_in;
      len_up_ff <= len_up_in;
      len_eq_ff <= len_eq_in;
      len_dn_ff <= len_dn_in;
      out_ff    <= out_in;
   end

   always_comb begin
      status.non_positive = clamp_ff[RW-1] || (clamp_ff == '0);
      status.is_max       = is_max_ff;
      status.count_zero   = (count_ff == '0);
      status.last_packet  = last_w;
      status.out_free     = out_free;
   end

   assign rsp_payload = out_ff;
   assign rsp_valid   = out_valid_ff;

endmodule

FILE: src/iso_packet_length_planner_top.sv
// Top level of the iso packet length planner: CSR bank, controller and datapath.
// Depends on iplp_pkg, iplp_stream_if, iplp_csr, iplp_ctrl and iplp_datapath.
//
//   channel  direction  word                                        handshake
//   req_ch   in         feedback_rate (signed, FRAC_BITS fraction)  valid/ready
//   rsp_ch   out        packet_offset, packet_length, zero_fill,    valid/ready
//                       last_packet
//   csr_*    in         channel_count .. default_rate by index      csr_we, no wait
//
// One request is worked at a time. A request passes the setup steps clamp,
// round and length plan (a zero-fill request skips the plan) and then gives
// one result word per cycle while rsp_ch is free; the single accumulator
// update per packet sets that pace. The result register lets the
// next request enter while the last word still waits on rsp_ch. A stall on
// rsp_ch holds the sequencer at the current packet. Reset is synchronous and
// clears the accumulator, the sequencer and loads the register reset values.
module iso_packet_length_planner_top #(
   parameter int unsigned MAX_PACKETS = iplp_pkg::MAX_PACKETS_DEF,
   parameter int unsigned FRAC_BITS   = iplp_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   iplp_stream_if.sink                      req_ch,
   iplp_stream_if.source                    rsp_ch,
   input  logic                             csr_we,
   input  logic [iplp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [iplp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   iplp_pkg::cfg_type         cfg;
   iplp_pkg::cmd_type         cmd;
   iplp_pkg::status_type      status;
   iplp_pkg::rsp_payload_type rsp_payload;
   logic                      req_ready;
   logic                      rsp_valid;

   // Register bank; write it only while the sequencer is idle and no word is owed
   iplp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer: accept, clamp, round, then plan and emit packets, or emit one zero-fill word
   iplp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic, accumulator and result register
   iplp_datapath #(
      .MAX_PACKETS (MAX_PACKETS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_feedback_rate (req_ch.payload.feedback_rate),
      .rsp_payload       (rsp_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ch.ready)
   );

   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid;
   assign rsp_ch.payload = rsp_payload;

endmodule
